// File: rtl/core/assert_macros.svh
// Assertion macros used by the sorter datapath; define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clk edge outside reset.
`define DSS_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define DSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DSS_ASSERT_PROP(lbl, prop, msg)
`define DSS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/core/dss_pkg.sv
// Shared constants, payload types and control structs of the score sorter.
package dss_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int RANK_W      = 6;

  typedef struct packed {
    logic signed [31:0] entry_score;
    logic [7:0]         entry_tag;
    logic               entry_last;
  } entry_t;

  typedef struct packed {
    logic signed [31:0]  sorted_score;
    logic [7:0]          sorted_tag;
    logic [RANK_W-1:0]   rank_position;
    logic                run_last;
    logic                overflow;
  } result_t;

  // One stored list slot.
  typedef struct packed {
    logic signed [31:0] score;
    logic [7:0]         tag;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Controller to datapath.
  typedef struct packed {
    logic load_en;
    logic scan_start;
    logic scan_run;
    logic emit_load;
    logic emit_done;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic run_last;
  } sts_t;

endpackage

// File: rtl/core/dss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dss_datapath.sv
// Datapath: list store, fill count, selection scan and result register.
`include "assert_macros.svh"

module dss_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  dss_pkg::cmd_t    cmd,
  input  dss_pkg::entry_t  in_data,
  output dss_pkg::sts_t    sts,
  output dss_pkg::result_t out_data
);
  import dss_pkg::*;

  logic [CNT_W-1:0]       count_r;
  logic                   ovf_r;
  logic [MAX_ENTRIES-1:0] used_r;
  logic [IDX_W-1:0]       rank_r;
  logic [CNT_W-1:0]       rd_ptr_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   best_vld_r;
  slot_t                  best_r;
  logic [IDX_W-1:0]       best_idx_r;
  result_t                out_r;

  logic                   full;
  logic                   ram_we;
  slot_t                  ram_wslot;
  logic [IDX_W-1:0]       ram_raddr;
  logic [SLOT_W-1:0]      ram_rdata;
  slot_t                  rd_slot;
  logic                   issue;
  logic                   take;
  logic                   rank_last;

  assign full      = (count_r == CNT_W'(MAX_ENTRIES));
  assign ram_we    = cmd.load_en && !full;
  assign ram_wslot = '{score: in_data.entry_score, tag: in_data.entry_tag};
  assign ram_raddr = rd_ptr_r[IDX_W-1:0];
  assign rd_slot   = slot_t'(ram_rdata);
  assign issue     = cmd.scan_run && (rd_ptr_r != count_r);
  // strictly greater keeps the earliest of equal scores
  assign take      = rd_vld_r && !used_r[rd_idx_r] &&
                     (!best_vld_r || (rd_slot.score > best_r.score));
  assign rank_last = ((CNT_W'(rank_r) + CNT_W'(1)) == count_r);

  dss_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (SLOT_W'(ram_wslot)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      ovf_r      <= 1'b0;
      used_r     <= '0;
      rank_r     <= '0;
      rd_ptr_r   <= '0;
      rd_vld_r   <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      if (cmd.load_en) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CNT_W'(1);
        end
      end
      if (cmd.scan_start) begin
        rd_ptr_r   <= '0;
        rd_vld_r   <= 1'b0;
        best_vld_r <= 1'b0;
      end else begin
        rd_vld_r <= issue;
        if (issue) begin
          rd_ptr_r <= rd_ptr_r + CNT_W'(1);
        end
        if (take) begin
          best_vld_r <= 1'b1;
        end
      end
      if (cmd.emit_done) begin
        if (out_r.run_last) begin
          count_r <= '0;
          ovf_r   <= 1'b0;
          used_r  <= '0;
          rank_r  <= '0;
        end else begin
          used_r[best_idx_r] <= 1'b1;
          rank_r             <= rank_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= ram_raddr;
    if (take) begin
      best_r     <= rd_slot;
      best_idx_r <= rd_idx_r;
    end
    if (cmd.emit_load) begin
      out_r <= '{sorted_score:  best_r.score,
                 sorted_tag:    best_r.tag,
                 rank_position: RANK_W'(rank_r),
                 run_last:      rank_last,
                 overflow:      ovf_r};
    end
  end

  assign sts.scan_done = (rd_ptr_r == count_r) && !rd_vld_r;
  assign sts.run_last  = out_r.run_last;
  assign out_data      = out_r;

  `DSS_ASSERT_NEVER(a_count_max, count_r > CNT_W'(MAX_ENTRIES), "fill count above capacity")
  `DSS_ASSERT_PROP(a_best_found, cmd.emit_load |-> best_vld_r, "scan ended with no candidate")
  `DSS_ASSERT_PROP(a_run_clear, cmd.emit_done && sts.run_last |=> count_r == '0, "run not cleared")

endmodule

// File: rtl/core/dss_ctrl.sv
// Controller: load, scan and emit sequencing of the sorter.
module dss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  input  logic          out_stall,
  input  dss_pkg::sts_t sts,
  output logic          in_stall,
  output logic          out_valid,
  output dss_pkg::cmd_t cmd
);
  import dss_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd.load_en    = (state_r == ST_LOAD) && in_valid;
    cmd.scan_run   = (state_r == ST_SCAN);
    cmd.emit_load  = (state_r == ST_SCAN) && sts.scan_done;
    cmd.emit_done  = (state_r == ST_EMIT) && !out_stall;
    cmd.scan_start = (cmd.load_en && in_last) || (cmd.emit_done && !sts.run_last);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (cmd.load_en && in_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.emit_done) state_nxt = sts.run_last ? ST_LOAD : ST_SCAN;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_LOAD);
  assign out_valid = (state_r == ST_EMIT);

endmodule

// File: rtl/core/descending_score_sorter.sv
// Top level of the descending score sorter: controller plus datapath.
// Load: one transfer per cycle while collecting a list (n entries, n <= 16 kept).
// Sort/emit: each rank scans the store through its single read port, then holds the result until out_stall is low.
// First result is offered once the first scan of the stored list completes.
// Reset (rst_n low, synchronous) empties the list; store contents need no clearing.
module descending_score_sorter (
  input  logic             clk,
  input  logic             rst_n,
  // entry channel
  input  logic             in_valid,
  output logic             in_stall,
  input  dss_pkg::entry_t  in_data,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output dss_pkg::result_t out_data
);
  import dss_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accepts entries only while loading; one result per emit phase.
  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.entry_last),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Store and selection: each scan picks the highest unused score, earliest
  // arrival winning ties, which matches a stable descending sort.
  dss_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
